@@ hw/rtl/slfw_pkg.sv @@
// Package for the serial LCD frame writer: request/result structs, opcodes,
// command length table and the control state type. No dependencies.

package slfw_pkg;

    localparam int unsigned HELD_DEPTH = 5;

    localparam logic KIND_SERIAL = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    // Command opcodes
    localparam logic [7:0] OP_SWRESET = 8'h01;
    localparam logic [7:0] OP_CASET   = 8'h2A;
    localparam logic [7:0] OP_RASET   = 8'h2B;
    localparam logic [7:0] OP_RAMWR   = 8'h2C;
    localparam logic [7:0] OP_MADCTL  = 8'h36;
    localparam logic [7:0] OP_COLMOD  = 8'h3A;
    localparam logic [7:0] OP_FRMCTR1 = 8'hB1;
    localparam logic [7:0] OP_FRMCTR2 = 8'hB2;
    localparam logic [7:0] OP_FRMCTR3 = 8'hB3;
    localparam logic [7:0] OP_INVCTR  = 8'hB4;
    localparam logic [7:0] OP_DISSET5 = 8'hB6;
    localparam logic [7:0] OP_PWCTR1  = 8'hC0;
    localparam logic [7:0] OP_PWCTR2  = 8'hC1;
    localparam logic [7:0] OP_PWCTR3  = 8'hC2;
    localparam logic [7:0] OP_PWCTR4  = 8'hC3;
    localparam logic [7:0] OP_PWCTR5  = 8'hC4;
    localparam logic [7:0] OP_VMCTR1  = 8'hC5;
    localparam logic [7:0] OP_GMCTRP1 = 8'hE0;
    localparam logic [7:0] OP_GMCTRN1 = 8'hE1;
    localparam logic [7:0] OP_PWCTR6  = 8'hFC;

    typedef struct packed {
        logic       kind;
        logic       data_bit;
        logic [6:0] read_row;
        logic [7:0] read_col;
    } t_in_item;

    typedef struct packed {
        logic        byte_done;
        logic        pixel_written;
        logic [6:0]  pixel_row;
        logic [7:0]  pixel_col;
        logic [15:0] pixel_color;
        logic        line_done;
        logic        write_mode;
        logic [15:0] read_data;
    } t_out_item;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

    // Command length in bytes, opcode included
    function automatic logic [4:0] cmd_length(input logic [7:0] op);
        logic [4:0] len;
        case (op)
            OP_COLMOD, OP_MADCTL, OP_INVCTR, OP_PWCTR2: len = 5'd2;
            OP_DISSET5, OP_PWCTR1, OP_PWCTR3, OP_PWCTR4, OP_PWCTR5, OP_PWCTR6,
            OP_VMCTR1: len = 5'd3;
            OP_FRMCTR1, OP_FRMCTR2: len = 5'd4;
            OP_CASET, OP_RASET: len = 5'd5;
            OP_FRMCTR3: len = 5'd7;
            OP_GMCTRP1, OP_GMCTRN1: len = 5'd17;
            default: len = 5'd1;
        endcase
        return len;
    endfunction

endpackage

@@ hw/rtl/slfw_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.

module slfw_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 20480
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/serial_lcd_frame_writer_top.sv @@
// Serial LCD frame writer: bit assembly, command decode, window pointers and
// frame memory. Depends on slfw_pkg and slfw_ram.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------------
//  request   | start / busy              | i_req  (t_in_item)
//  result    | o_res_valid (one cycle)   | o_res  (t_out_item)
//
// One request per clock while busy is low; its result shows in the cycle after
// acceptance (frame memory read latency sets that delay for read requests).
// After reset, and after a software reset command, the frame memory is swept
// to zero one entry a cycle, with busy high until the sweep ends.
// The receiver cannot stall: each result is valid for exactly one cycle.

module serial_lcd_frame_writer_top
    import slfw_pkg::*;
#(
    parameter int unsigned PANEL_WIDTH  = 160,
    parameter int unsigned PANEL_HEIGHT = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_req,
    output logic      o_res_valid,
    output t_out_item o_res
);

    localparam int unsigned DEPTH  = PANEL_WIDTH * PANEL_HEIGHT;
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_state r_state, n_state;

    logic [7:0]  r_shift, n_shift;
    logic [2:0]  r_bit_cnt, n_bit_cnt;
    logic [4:0]  r_byte_cnt, n_byte_cnt;
    logic [7:0]  r_held [HELD_DEPTH];
    logic [7:0]  n_held [HELD_DEPTH];
    logic [15:0] r_col_start, n_col_start;
    logic [15:0] r_col_end, n_col_end;
    logic [15:0] r_row_start, n_row_start;
    logic [15:0] r_row_end, n_row_end;
    logic [15:0] r_col_ptr, n_col_ptr;
    logic [15:0] r_row_ptr, n_row_ptr;
    logic        r_pix_mode, n_pix_mode;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;

    logic        r_res_valid;
    t_out_item   r_res, n_res;
    logic        r_rd_ok, n_rd_ok;

    logic              accept;
    logic              sw_reset;
    logic              complete;
    logic [4:0]        cnt_inc;
    logic [7:0]        op;
    logic [15:0]       color;
    logic [15:0]       col_inc;
    logic [15:0]       row_inc;
    logic              pix_we;
    logic [ADDR_W-1:0] pix_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              clearing;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [15:0]       ram_wdata;
    logic [15:0]       ram_rdata;

    assign accept = start && !busy;

    // Serial step and read request decode
    always_comb begin
        n_shift     = r_shift;
        n_bit_cnt   = r_bit_cnt;
        n_byte_cnt  = r_byte_cnt;
        n_held      = r_held;
        n_col_start = r_col_start;
        n_col_end   = r_col_end;
        n_row_start = r_row_start;
        n_row_end   = r_row_end;
        n_col_ptr   = r_col_ptr;
        n_row_ptr   = r_row_ptr;
        n_pix_mode  = r_pix_mode;
        n_res       = '0;
        n_rd_ok     = 1'b0;
        sw_reset    = 1'b0;
        complete    = 1'b0;
        cnt_inc     = r_byte_cnt + 5'd1;
        op          = 8'h00;
        color       = 16'h0000;
        col_inc     = r_col_ptr + 16'd1;
        row_inc     = r_row_ptr + 16'd1;
        pix_we      = 1'b0;
        pix_addr    = ADDR_W'(32'(r_row_ptr) * PANEL_WIDTH + 32'(r_col_ptr));
        rd_en       = 1'b0;
        rd_addr     = ADDR_W'(32'(i_req.read_row) * PANEL_WIDTH + 32'(i_req.read_col));

        if (accept && i_req.kind == KIND_READ) begin
            rd_en   = 1'b1;
            n_rd_ok = (32'(i_req.read_row) < PANEL_HEIGHT) &&
                      (32'(i_req.read_col) < PANEL_WIDTH);
        end else if (accept) begin
            n_shift   = {r_shift[6:0], i_req.data_bit};
            n_bit_cnt = r_bit_cnt + 3'd1;
            if (r_bit_cnt == 3'd7) begin
                n_res.byte_done = 1'b1;
                for (int i = 0; i < HELD_DEPTH; i++) begin
                    if (r_byte_cnt == 5'(i)) begin
                        n_held[i] = n_shift;
                    end
                end
                n_byte_cnt = cnt_inc;
                if (r_pix_mode) begin
                    complete = (cnt_inc >= 5'd2);
                    if (complete) begin
                        color = {n_held[0], n_held[1]};
                        if (r_col_ptr < 16'(PANEL_WIDTH) && r_row_ptr < 16'(PANEL_HEIGHT)) begin
                            pix_we              = 1'b1;
                            n_res.pixel_written = 1'b1;
                            n_res.pixel_row     = r_row_ptr[6:0];
                            n_res.pixel_col     = r_col_ptr[7:0];
                            n_res.pixel_color   = color;
                        end
                        n_col_ptr = col_inc;
                        // wrap to window start and step the row
                        if (col_inc > r_col_end) begin
                            n_res.line_done = 1'b1;
                            n_col_ptr       = r_col_start;
                            n_row_ptr       = row_inc;
                            if (row_inc > r_row_end) begin
                                n_pix_mode = 1'b0;
                            end
                        end
                    end
                end else begin
                    op       = n_held[0];
                    complete = (cnt_inc >= cmd_length(op));
                    case (op)
                        OP_SWRESET: begin
                            sw_reset = 1'b1;
                        end
                        OP_CASET: begin
                            if (complete) begin
                                n_col_start = {n_held[1], n_held[2]};
                                n_col_end   = {n_held[3], n_held[4]};
                            end
                        end
                        OP_RASET: begin
                            if (complete) begin
                                n_row_start = {n_held[1], n_held[2]};
                                n_row_end   = {n_held[3], n_held[4]};
                            end
                        end
                        OP_RAMWR: begin
                            n_col_ptr  = r_col_start;
                            n_row_ptr  = r_row_start;
                            n_pix_mode = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
                if (complete) begin
                    n_byte_cnt = 5'd0;
                end
                // software reset: drop all serial and window state
                if (sw_reset) begin
                    n_shift     = 8'h00;
                    n_bit_cnt   = 3'd0;
                    n_byte_cnt  = 5'd0;
                    n_col_start = 16'h0000;
                    n_col_end   = 16'h0000;
                    n_row_start = 16'h0000;
                    n_row_end   = 16'h0000;
                    n_col_ptr   = 16'h0000;
                    n_row_ptr   = 16'h0000;
                    n_pix_mode  = 1'b0;
                end
            end
        end
        n_res.write_mode = n_pix_mode;
    end

    // Control state: next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (sw_reset) begin
                    n_state = ST_CLEAR;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Control state: outputs
    always_comb begin
        clearing   = 1'b0;
        n_clr_addr = '0;
        case (r_state)
            ST_CLEAR: begin
                clearing   = 1'b1;
                n_clr_addr = r_clr_addr + ADDR_W'(1);
            end
            ST_RUN: begin
                clearing = 1'b0;
            end
            default: begin
                clearing = 1'b1;
            end
        endcase
    end

    assign busy = clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_shift     <= 8'h00;
            r_bit_cnt   <= 3'd0;
            r_byte_cnt  <= 5'd0;
            r_col_start <= 16'h0000;
            r_col_end   <= 16'h0000;
            r_row_start <= 16'h0000;
            r_row_end   <= 16'h0000;
            r_col_ptr   <= 16'h0000;
            r_row_ptr   <= 16'h0000;
            r_pix_mode  <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_shift     <= n_shift;
            r_bit_cnt   <= n_bit_cnt;
            r_byte_cnt  <= n_byte_cnt;
            r_col_start <= n_col_start;
            r_col_end   <= n_col_end;
            r_row_start <= n_row_start;
            r_row_end   <= n_row_end;
            r_col_ptr   <= n_col_ptr;
            r_row_ptr   <= n_row_ptr;
            r_pix_mode  <= n_pix_mode;
            r_res_valid <= accept;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_held <= n_held;
        if (accept) begin
            r_res   <= n_res;
            r_rd_ok <= n_rd_ok;
        end
    end

    // Sweep writes zeros; otherwise the pixel store owns the write port
    assign ram_we    = clearing || pix_we;
    assign ram_waddr = clearing ? r_clr_addr : pix_addr;
    assign ram_wdata = clearing ? 16'h0000 : color;

    slfw_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_res           = r_res;
        o_res.read_data = r_rd_ok ? ram_rdata : 16'h0000;
    end

    assign o_res_valid = r_res_valid;

    // Every accepted request yields a result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_res_valid)
        else $error("accepted request produced no result");

    // Read data only ever answers a read request
    a_read_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.read_data != 16'h0000) |->
            $past(accept && i_req.kind == KIND_READ))
        else $error("read data on a serial result");

    // The sweep owns the frame memory write port alone
    a_no_store_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !pix_we)
        else $error("pixel store during memory clear");

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for serial_lcd_frame_writer_top: shifts in command and
// pixel bytes bit by bit, reads pixels back and checks every result against a
// local model of the controller. Depends on slfw_pkg and the frame writer RTL.

module testbench;
    import slfw_pkg::*;

    localparam int unsigned PANEL_W      = 160;
    localparam int unsigned PANEL_H      = 128;
    localparam int unsigned FRAME_LEN    = PANEL_W * PANEL_H;
    localparam int unsigned RANDOM_ITEMS = 1700;
    localparam int unsigned STALL_LIMIT  = 100000;
    localparam int unsigned TAIL_CYCLES  = 8;
    localparam int unsigned MAX_PRINTS   = 40;
    localparam int          DIRECTED_ROWS = 31;

    typedef struct packed {
        logic        is_read;
        logic [7:0]  value;
        logic [6:0]  row;
        logic [7:0]  col;
        logic        typed;
        logic [15:0] want_data;
    } t_directed_row;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    logic      busy;
    t_in_item  i_req   = '0;
    logic      o_res_valid;
    t_out_item o_res;

    // expectation typed into the table, carried alongside the request
    logic      req_typed     = 1'b0;
    t_out_item req_typed_res = '0;

    always #5 i_clk = ~i_clk;

    serial_lcd_frame_writer_top #(
        .PANEL_WIDTH  (PANEL_W),
        .PANEL_HEIGHT (PANEL_H)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    // ------------------------------------------------------------------
    // Controller model
    // ------------------------------------------------------------------
    logic [7:0]  lcd_shift;
    logic [2:0]  lcd_bits;
    logic [4:0]  lcd_nbytes;
    logic [7:0]  lcd_held [HELD_DEPTH];
    logic [15:0] col_first, col_last, row_first, row_last;
    logic [15:0] col_ptr, row_ptr;
    logic        in_pixels;
    logic [15:0] frame_mem [FRAME_LEN];

    t_out_item   lcd_results_due [$];
    t_out_item   want;
    int unsigned mismatches = 0;
    int unsigned stall_cycles = 0;

    function automatic int unsigned bytes_in_command(logic [7:0] op);
        case (op)
            OP_COLMOD, OP_MADCTL, OP_INVCTR, OP_PWCTR2: return 2;
            OP_DISSET5, OP_PWCTR1, OP_PWCTR3, OP_PWCTR4, OP_PWCTR5, OP_PWCTR6,
            OP_VMCTR1: return 3;
            OP_FRMCTR1, OP_FRMCTR2: return 4;
            OP_CASET, OP_RASET: return 5;
            OP_FRMCTR3: return 7;
            OP_GMCTRP1, OP_GMCTRN1: return 17;
            default: return 1;
        endcase
    endfunction

    function automatic void clear_lcd_model();
        lcd_shift  = '0;
        lcd_bits   = '0;
        lcd_nbytes = '0;
        for (int k = 0; k < HELD_DEPTH; k++) lcd_held[k] = '0;
        col_first = '0;
        col_last  = '0;
        row_first = '0;
        row_last  = '0;
        col_ptr   = '0;
        row_ptr   = '0;
        in_pixels = 1'b0;
        for (int k = 0; k < FRAME_LEN; k++) frame_mem[k] = '0;
    endfunction

    function automatic t_out_item predict_lcd_step(t_in_item req);
        t_out_item   res;
        logic [7:0]  op;
        logic [15:0] colour;
        bit          complete;
        int unsigned pos;
        res = '0;
        if (req.kind == KIND_READ) begin
            if (req.read_row < PANEL_H && req.read_col < PANEL_W)
                res.read_data = frame_mem[int'(req.read_row) * PANEL_W + int'(req.read_col)];
        end else begin
            lcd_shift = {lcd_shift[6:0], req.data_bit};
            lcd_bits  = lcd_bits + 3'd1;
            if (lcd_bits == 3'd0) begin
                res.byte_done = 1'b1;
                pos = 32'(lcd_nbytes);
                if (pos < HELD_DEPTH) lcd_held[pos] = lcd_shift;
                lcd_nbytes = lcd_nbytes + 5'd1;
                if (in_pixels) begin
                    complete = (lcd_nbytes >= 5'd2);
                    if (complete) begin
                        colour = {lcd_held[0], lcd_held[1]};
                        if (col_ptr < PANEL_W && row_ptr < PANEL_H) begin
                            frame_mem[int'(row_ptr) * PANEL_W + int'(col_ptr)] = colour;
                            res.pixel_written = 1'b1;
                            res.pixel_row     = row_ptr[6:0];
                            res.pixel_col     = col_ptr[7:0];
                            res.pixel_color   = colour;
                        end
                        col_ptr = col_ptr + 16'd1;
                        if (col_ptr > col_last) begin
                            res.line_done = 1'b1;
                            col_ptr = col_first;
                            row_ptr = row_ptr + 16'd1;
                            if (row_ptr > row_last) in_pixels = 1'b0;
                        end
                    end
                end else begin
                    op = lcd_held[0];
                    complete = (lcd_nbytes >= bytes_in_command(op));
                    if (op == OP_SWRESET) begin
                        clear_lcd_model();
                    end else if (op == OP_CASET && complete) begin
                        col_first = {lcd_held[1], lcd_held[2]};
                        col_last  = {lcd_held[3], lcd_held[4]};
                    end else if (op == OP_RASET && complete) begin
                        row_first = {lcd_held[1], lcd_held[2]};
                        row_last  = {lcd_held[3], lcd_held[4]};
                    end else if (op == OP_RAMWR) begin
                        col_ptr   = col_first;
                        row_ptr   = row_first;
                        in_pixels = 1'b1;
                    end
                end
                if (complete) lcd_nbytes = '0;
                lcd_bits = '0;
            end
        end
        res.write_mode = in_pixels;
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS) $display("%0t ns: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s is %h, should be %h", name, got, exp_val));
    endtask

    // Sample everything as it stood before the edge: results first, then requests
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_lcd_model();
            lcd_results_due.delete();
            stall_cycles = 0;
        end else begin
            if (o_res_valid === 1'b1) begin
                if (lcd_results_due.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    want = lcd_results_due.pop_front();
                    check_field("byte_done", 16'(o_res.byte_done), 16'(want.byte_done));
                    check_field("pixel_written", 16'(o_res.pixel_written),
                                16'(want.pixel_written));
                    check_field("pixel_row", 16'(o_res.pixel_row), 16'(want.pixel_row));
                    check_field("pixel_col", 16'(o_res.pixel_col), 16'(want.pixel_col));
                    check_field("pixel_color",   o_res.pixel_color,   want.pixel_color);
                    check_field("line_done", 16'(o_res.line_done), 16'(want.line_done));
                    check_field("write_mode", 16'(o_res.write_mode), 16'(want.write_mode));
                    check_field("read_data",     o_res.read_data,     want.read_data);
                end
            end
            if (start && !busy) begin
                want = predict_lcd_step(i_req);
                if (req_typed) want = req_typed_res;
                lcd_results_due.push_back(want);
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("no request accepted for %0d cycles", stall_cycles);
                    $display("CHECK FAILED");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    int unsigned items_sent = 0;
    bit          calm = 1'b0;
    bit          mix_reads = 1'b0;
    logic [15:0] gen_col_lo = '0, gen_col_hi = '0, gen_row_lo = '0, gen_row_hi = '0;
    logic [6:0]  near_row = '0;
    logic [7:0]  near_col = '0;
    t_directed_row directed [DIRECTED_ROWS];

    task automatic issue(t_in_item req, bit typed, t_out_item typed_res);
        calm = (items_sent >= 500 && items_sent < 800);
        while (!calm && $urandom_range(0, 99) < 14) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_req         <= req;
        req_typed     <= typed;
        req_typed_res <= typed_res;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic read_pixel(logic [6:0] row, logic [7:0] col, bit typed,
                              logic [15:0] want_data);
        t_in_item  req;
        t_out_item res;
        req.kind     = KIND_READ;
        req.data_bit = 1'($urandom_range(0, 1));
        req.read_row = row;
        req.read_col = col;
        res = '0;
        res.read_data = want_data;
        issue(req, typed, res);
    endtask

    task automatic random_read();
        logic [6:0] row;
        logic [7:0] col;
        // favour the area last written so reads return real data
        if ($urandom_range(0, 1)) begin
            row = near_row + 7'($urandom_range(0, 3));
            col = near_col + 8'($urandom_range(0, 5));
        end else begin
            row = 7'($urandom_range(0, 127));
            col = 8'($urandom_range(0, 255));
        end
        read_pixel(row, col, 1'b0, '0);
    endtask

    task automatic send_byte(logic [7:0] value);
        t_in_item req;
        int       i;
        for (i = 7; i >= 0; i--) begin
            if (mix_reads && $urandom_range(0, 99) < 6) random_read();
            req.kind     = KIND_SERIAL;
            req.data_bit = value[i];
            req.read_row = 7'($urandom);
            req.read_col = 8'($urandom);
            issue(req, 1'b0, '0);
        end
    endtask

    task automatic send_window(logic [7:0] op, logic [15:0] lo, logic [15:0] hi);
        send_byte(op);
        send_byte(lo[15:8]);
        send_byte(lo[7:0]);
        send_byte(hi[15:8]);
        send_byte(hi[7:0]);
    endtask

    // Window bounds: mostly small spans inside the panel, some across the edge,
    // reversed, wrapping past 0xFFFF or entirely off the panel
    task automatic pick_span(input bit is_col, output logic [15:0] lo, output logic [15:0] hi);
        int unsigned lim, span, pick;
        lim  = is_col ? PANEL_W : PANEL_H;
        span = is_col ? 5 : 3;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            lo = 16'($urandom_range(0, lim - 1));
            hi = lo + 16'($urandom_range(0, span));
        end else if (pick < 70) begin
            lo = 16'(lim - $urandom_range(1, span));
            hi = lo + 16'($urandom_range(0, span));
        end else if (pick < 80) begin
            lo = 16'($urandom_range(5, lim - 1));
            hi = lo - 16'($urandom_range(1, 5));
        end else if (pick < 90) begin
            lo = 16'hFFFF - 16'($urandom_range(0, is_col ? 1 : 0));
            hi = 16'($urandom_range(0, is_col ? 3 : 1));
        end else begin
            lo = 16'($urandom_range(lim, 16'hFFF0));
            hi = lo + 16'($urandom_range(0, span - 1));
        end
    endtask

    function automatic int unsigned pixels_in_window(logic [15:0] clo, logic [15:0] chi,
                                                     logic [15:0] rlo, logic [15:0] rhi);
        logic [15:0] c, r;
        int unsigned n;
        c = clo;
        r = rlo;
        for (n = 1; n < 4096; n++) begin
            c = c + 16'd1;
            if (c > chi) begin
                c = clo;
                r = r + 16'd1;
                if (r > rhi) return n;
            end
        end
        return n;
    endfunction

    task automatic send_ramwr();
        logic [15:0] colour;
        int unsigned count;
        count = pixels_in_window(gen_col_lo, gen_col_hi, gen_row_lo, gen_row_hi);
        near_row = (gen_row_lo < PANEL_H) ? gen_row_lo[6:0] : '0;
        near_col = (gen_col_lo < PANEL_W) ? gen_col_lo[7:0] : '0;
        send_byte(OP_RAMWR);
        // send the whole window so pixel mode ends and commands parse again
        repeat (count) begin
            case ($urandom_range(0, 9))
                0: colour = 16'h0000;
                1: colour = 16'hFFFF;
                default: colour = 16'($urandom);
            endcase
            send_byte(colour[15:8]);
            send_byte(colour[7:0]);
        end
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (lcd_results_due.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int unsigned n, pick, stop_at;
        logic [7:0]  op;
        bit          drained;

        directed = '{
            '{1'b1, 8'h00, 7'd0,   8'd0,   1'b1, 16'h0000},  // memory clear after reset
            '{1'b1, 8'h00, 7'd127, 8'd159, 1'b1, 16'h0000},
            '{1'b1, 8'h00, 7'd127, 8'd255, 1'b1, 16'h0000},  // column off the panel
            '{1'b0, OP_CASET, 7'd0, 8'd0, 1'b0, 16'h0000},
            '{1'b0, 8'h00, 7'd0, 8'd0, 1'b0, 16'h0000},
            '{1'b0, 8'h9E, 7'd0, 8'd0, 1'b0, 16'h0000},
            '{1'b0, 8'h00, 7'd0, 8'd0, 1'b0, 16'h0000},
            '{1'b0, 8'h9F, 7'd0, 8'd0, 1'b0, 16'h0000},
            '{1'b0, OP_RASET, 7'd0, 8'd0, 1'b0, 16'h0000},
            '{1'b0, 8'h00, 7'd0, 8'd0, 1'b0, 16'h0000},
            '{1'b0, 8'h7E, 7'd0, 8'd0, 1'b0, 16'h0000},
            '{1'b0, 8'h00, 7'd0, 8'd0, 1'b0, 16'h0000},
            '{1'b0, 8'h80, 7'd0, 8'd0, 1'b0, 16'h0000},  // last row below the panel
            '{1'b0, OP_RAMWR, 7'd0, 8'd0, 1'b0, 16'h0000},
            '{1'b0, 8'hFF, 7'd0, 8'd0, 1'b0, 16'h0000},
            '{1'b0, 8'hFF, 7'd0, 8'd0, 1'b0, 16'h0000},
            '{1'b0, 8'h00, 7'd0, 8'd0, 1'b0, 16'h0000},
            '{1'b0, 8'h00, 7'd0, 8'd0, 1'b0, 16'h0000},
            '{1'b0, 8'hA5, 7'd0, 8'd0, 1'b0, 16'h0000},
            '{1'b0, 8'h5A, 7'd0, 8'd0, 1'b0, 16'h0000},
            '{1'b0, 8'h12, 7'd0, 8'd0, 1'b0, 16'h0000},
            '{1'b0, 8'h34, 7'd0, 8'd0, 1'b0, 16'h0000},
            '{1'b0, 8'h00, 7'd0, 8'd0, 1'b0, 16'h0000},
            '{1'b0, 8'h01, 7'd0, 8'd0, 1'b0, 16'h0000},
            '{1'b0, 8'h80, 7'd0, 8'd0, 1'b0, 16'h0000},
            '{1'b0, 8'h00, 7'd0, 8'd0, 1'b0, 16'h0000},
            '{1'b1, 8'h00, 7'd127, 8'd159, 1'b0, 16'h0000},
            '{1'b1, 8'h00, 7'd126, 8'd158, 1'b0, 16'h0000},
            '{1'b0, 8'h5F, 7'd0, 8'd0, 1'b0, 16'h0000},      // unknown opcode
            '{1'b0, OP_SWRESET, 7'd0, 8'd0, 1'b0, 16'h0000},
            '{1'b1, 8'h00, 7'd127, 8'd159, 1'b1, 16'h0000}   // wiped by software reset
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (n = 0; n < DIRECTED_ROWS; n++) begin
            if (directed[n].is_read)
                read_pixel(directed[n].row, directed[n].col, directed[n].typed,
                           directed[n].want_data);
            else
                send_byte(directed[n].value);
        end

        mix_reads = 1'b1;
        drained   = 1'b0;
        stop_at   = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            if (!drained && items_sent > stop_at - RANDOM_ITEMS / 2) begin
                wait_for_results();
                drained = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                if ($urandom_range(0, 99) < 85) begin
                    pick_span(1'b1, gen_col_lo, gen_col_hi);
                    send_window(OP_CASET, gen_col_lo, gen_col_hi);
                end
                if ($urandom_range(0, 99) < 85) begin
                    pick_span(1'b0, gen_row_lo, gen_row_hi);
                    send_window(OP_RASET, gen_row_lo, gen_row_hi);
                end
                if ($urandom_range(0, 99) < 90) send_ramwr();
            end else if (pick < 58) begin
                send_ramwr();
            end else if (pick < 78) begin
                // setup command with parameters, long gamma tables included
                do op = 8'($urandom);
                while (bytes_in_command(op) == 1 || op == OP_CASET || op == OP_RASET);
                send_byte(op);
                repeat (bytes_in_command(op) - 1) send_byte(8'($urandom));
            end else if (pick < 88) begin
                do op = 8'($urandom);
                while (bytes_in_command(op) != 1 || op == OP_SWRESET || op == OP_RAMWR);
                send_byte(op);
            end else if (pick < 97) begin
                repeat ($urandom_range(1, 6)) random_read();
            end else begin
                send_byte(OP_SWRESET);
                gen_col_lo = '0;
                gen_col_hi = '0;
                gen_row_lo = '0;
                gen_row_hi = '0;
            end
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
